// ===== rtl/core/mxy_pkg.sv =====
package mxy_pkg;

    localparam int NUM_PORTS        = 5;
    localparam int FLIT_W           = 34;
    localparam int ID_W             = 4;
    localparam int PORT_W           = 3;
    localparam int KIND_HI          = 33;
    localparam int KIND_LO          = 32;
    localparam int DEST_HI          = 31;
    localparam int DEST_LO          = 28;
    localparam int DEF_QUEUE_DEPTH  = 8;
    localparam int DEF_MESH_COLUMNS = 4;

    typedef logic [FLIT_W-1:0] t_flit;

    typedef enum logic [1:0] {
        KIND_HEAD = 2'd0,
        KIND_BODY = 2'd1,
        KIND_TAIL = 2'd2,
        KIND_RSVD = 2'd3
    } t_kind;

    typedef enum logic [PORT_W-1:0] {
        PORT_LOCAL = 3'd0,
        PORT_NORTH = 3'd1,
        PORT_EAST  = 3'd2,
        PORT_SOUTH = 3'd3,
        PORT_WEST  = 3'd4
    } t_port;

    typedef struct packed {
        logic  valid_local;
        logic  valid_north;
        logic  valid_east;
        logic  valid_south;
        logic  valid_west;
        t_flit flit_local;
        t_flit flit_north;
        t_flit flit_east;
        t_flit flit_south;
        t_flit flit_west;
    } t_in_req;

    typedef struct packed {
        logic                 send_valid;
        logic [PORT_W-1:0]    send_port;
        t_flit                send_flit;
        logic [NUM_PORTS-1:0] accept_mask;
    } t_out_req;

    // front-of-queue view of one input lane
    typedef struct packed {
        logic              ne;
        logic [PORT_W-1:0] port;
        t_flit             flit;
    } t_lane_stat;

    // dimension-order route: X first, then Y
    function automatic logic [PORT_W-1:0] pick_route(
        input logic [ID_W-1:0] id,
        input logic [ID_W-1:0] dest,
        input int              cols
    );
        logic [ID_W-1:0]   cx;
        logic [ID_W-1:0]   cy;
        logic [ID_W-1:0]   dx;
        logic [ID_W-1:0]   dy;
        logic [PORT_W-1:0] port;
        cy = '0;
        dy = '0;
        for (int q = 0; q < (1 << ID_W); q++) begin
            if (int'(id) >= q * cols) cy = ID_W'(q);
            if (int'(dest) >= q * cols) dy = ID_W'(q);
        end
        cx = ID_W'(int'(id) - int'(cy) * cols);
        dx = ID_W'(int'(dest) - int'(dy) * cols);
        priority if (dest == id) port = PORT_LOCAL;
        else if (dx > cx)        port = PORT_EAST;
        else if (dx < cx)        port = PORT_WEST;
        else if (dy > cy)        port = PORT_SOUTH;
        else if (dy < cy)        port = PORT_NORTH;
        else                     port = PORT_LOCAL;
        return port;
    endfunction

endpackage

// ===== rtl/core/mxy_lane.sv =====
module mxy_lane #(
    parameter int QUEUE_DEPTH  = mxy_pkg::DEF_QUEUE_DEPTH,
    parameter int MESH_COLUMNS = mxy_pkg::DEF_MESH_COLUMNS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mxy_pkg::ID_W-1:0] i_id,
    input  logic                     i_push,
    input  mxy_pkg::t_flit           i_flit,
    input  logic                     i_pop,
    output mxy_pkg::t_lane_stat      o_stat,
    output logic                     o_accept
);
    import mxy_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_flit             r_mem [QUEUE_DEPTH];
    t_flit             r_front;
    logic [PTR_W-1:0]  r_rptr;
    logic [PTR_W-1:0]  n_rptr;
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  n_wptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [PORT_W-1:0] r_route;
    logic [PORT_W-1:0] w_route;
    logic              w_push;

    // a slot freed by this tick's send can take the arrival
    assign w_push   = i_push && ((r_count != CNT_W'(QUEUE_DEPTH)) || i_pop);
    assign o_accept = w_push;

    assign n_rptr  = !i_pop ? r_rptr :
                     (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
    assign n_wptr  = !w_push ? r_wptr :
                     (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_count = r_count + CNT_W'(w_push) - CNT_W'(i_pop);

    assign w_route = (r_front[KIND_HI:KIND_LO] == KIND_HEAD) ?
                     pick_route(i_id, r_front[DEST_HI:DEST_LO], MESH_COLUMNS) : r_route;

    assign o_stat.ne   = (r_count != '0);
    assign o_stat.port = w_route;
    assign o_stat.flit = r_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr  <= '0;
            r_wptr  <= '0;
            r_count <= '0;
            r_route <= PORT_LOCAL;
        end else begin
            r_rptr  <= n_rptr;
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (i_pop) begin
                r_route <= w_route;
            end
        end
    end

    // storage with registered read of the next front, write-first bypass
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_flit;
        end
        if (w_push && (r_wptr == n_rptr)) begin
            r_front <= i_flit;
        end else begin
            r_front <= r_mem[n_rptr];
        end
    end

endmodule

// ===== rtl/core/mxy_merge.sv =====
module mxy_merge (
    input  mxy_pkg::t_lane_stat [mxy_pkg::NUM_PORTS-1:0] i_stat,
    input  logic                                         i_take,
    output logic [mxy_pkg::NUM_PORTS-1:0]                o_pop,
    output logic                                         o_send_valid,
    output logic [mxy_pkg::PORT_W-1:0]                   o_send_port,
    output mxy_pkg::t_flit                               o_send_flit
);
    import mxy_pkg::*;

    always_comb begin
        logic found;
        found        = 1'b0;
        o_pop        = '0;
        o_send_valid = 1'b0;
        o_send_port  = PORT_LOCAL;
        o_send_flit  = '0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (!found && i_stat[p].ne) begin
                found        = 1'b1;
                o_pop[p]     = i_take;
                o_send_valid = 1'b1;
                o_send_port  = i_stat[p].port;
                o_send_flit  = i_stat[p].flit;
            end
        end
    end

endmodule

// ===== rtl/core/mesh_xy_router_switch.sv =====
// Five-port XY mesh router, one request per tick unless the receiver stalls.
// Input channel (i_in_valid/o_in_ready, i_in_req): one request carries a
// valid bit and a 34-bit flit for each of the local, north, east, south and
// west ports. Each port feeds its own queue of QUEUE_DEPTH flits; a flit that
// finds its queue full, with no send from it, is dropped; accept_mask bit low.
// Output channel (o_out_valid/i_out_ready, o_out_req): exactly one result per
// request, registered, in the cycle after the request is accepted. It carries the
// flit sent by the lowest-numbered non-empty queue (as of before this request's
// arrivals), its output port and the accept mask of the arrivals.
// Throughput: one request per cycle when not stalled. Each queue is a memory
// with one write and one registered read port prefetching the next front flit.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data): router id, always
// ready; write it only while no request is in flight.
// Reset (synchronous, active low): queues empty, saved routes local, id 0.
// When the receiver stalls, the result holds and the input channel stalls
// with it; nothing is lost.
module mesh_xy_router_switch #(
    parameter int QUEUE_DEPTH  = mxy_pkg::DEF_QUEUE_DEPTH,
    parameter int MESH_COLUMNS = mxy_pkg::DEF_MESH_COLUMNS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  mxy_pkg::t_in_req         i_in_req,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output mxy_pkg::t_out_req        o_out_req,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [mxy_pkg::ID_W-1:0] i_cfg_data
);
    import mxy_pkg::*;

    logic [ID_W-1:0]                r_id;
    logic                           r_out_valid;
    t_out_req                       r_out_req;
    t_out_req                       n_out_req;
    logic                           w_take;
    logic [NUM_PORTS-1:0]           w_valid;
    t_flit [NUM_PORTS-1:0]          w_flit;
    t_lane_stat [NUM_PORTS-1:0]     w_stat;
    logic [NUM_PORTS-1:0]           w_pop;
    logic [NUM_PORTS-1:0]           w_accept;
    logic                           w_send_valid;
    logic [PORT_W-1:0]              w_send_port;
    t_flit                          w_send_flit;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_take      = i_in_valid && o_in_ready;

    assign w_valid = {i_in_req.valid_west, i_in_req.valid_south, i_in_req.valid_east,
                      i_in_req.valid_north, i_in_req.valid_local};
    assign w_flit  = {i_in_req.flit_west, i_in_req.flit_south, i_in_req.flit_east,
                      i_in_req.flit_north, i_in_req.flit_local};

    for (genvar p = 0; p < NUM_PORTS; p++) begin : g_lane
        mxy_lane #(
            .QUEUE_DEPTH  (QUEUE_DEPTH),
            .MESH_COLUMNS (MESH_COLUMNS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_id     (r_id),
            .i_push   (w_take && w_valid[p]),
            .i_flit   (w_flit[p]),
            .i_pop    (w_pop[p]),
            .o_stat   (w_stat[p]),
            .o_accept (w_accept[p])
        );
    end

    mxy_merge u_merge (
        .i_stat       (w_stat),
        .i_take       (w_take),
        .o_pop        (w_pop),
        .o_send_valid (w_send_valid),
        .o_send_port  (w_send_port),
        .o_send_flit  (w_send_flit)
    );

    always_comb begin
        n_out_req.send_valid  = w_send_valid;
        n_out_req.send_port   = w_send_port;
        n_out_req.send_flit   = w_send_flit;
        n_out_req.accept_mask = w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_id <= i_cfg_data;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef SYNTH
    a_pop_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_pop))
        else $error("more than one queue popped");

    a_accept_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ((w_accept & ~w_valid) == '0))
        else $error("accept bit without arriving flit");

    a_idle_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_req.send_valid) |->
            (o_out_req.send_port == PORT_LOCAL && o_out_req.send_flit == '0))
        else $error("idle send carries data");

    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (o_out_req.send_port <= PORT_WEST))
        else $error("send port out of range");
`endif

endmodule
